### rtl/mht_pkg.sv
package mht_pkg;

   localparam int DEFAULT_HEAP_DEPTH = 16;

   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_REJECTED = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_EXPIRED  = 3'd3;
   localparam logic [2:0] STATUS_DONE     = 3'd4;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_time;
      logic [31:0] timeout_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] expire_time;
      logic [31:0] expired_timeout;
      logic [4:0]  entries_left;
      logic [31:0] next_expire;
      logic        last;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [31:0] expiry;
      logic [31:0] timeout;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UP_READ,
      ST_UP_CMP,
      ST_UP_PLACE,
      ST_TICK_CHECK,
      ST_POP_LAST,
      ST_DN_READ_L,
      ST_DN_READ_R,
      ST_DN_SEL,
      ST_DN_CMP,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      sat_add = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

### rtl/mht_ram.sv
module mht_ram #(
   parameter int DEPTH = mht_pkg::DEFAULT_HEAP_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  mht_pkg::entry_type    wr_data,
   input  logic [AW-1:0]         rd_addr,
   output mht_pkg::entry_type    rd_data
);

   mht_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/mht_core.sv
module mht_core #(
   parameter int HEAP_DEPTH = mht_pkg::DEFAULT_HEAP_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mht_pkg::req_type req_data,
   output logic             res_valid,
   input  logic             res_ready,
   output mht_pkg::rsp_type res_data
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   mht_pkg::state_type state_ff, state_in;

   logic [CW-1:0]      count_ff, count_in;
   mht_pkg::entry_type root_ff, root_in;
   mht_pkg::req_type   item_ff, item_in;
   mht_pkg::entry_type cand_ff, cand_in;
   mht_pkg::entry_type left_ff, left_in;
   mht_pkg::entry_type best_ff, best_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic               has_right_ff, has_right_in;
   logic [2:0]         status_ff, status_in;
   logic [31:0]        res_exp_ff, res_exp_in;
   logic [31:0]        res_tmo_ff, res_tmo_in;
   logic               last_ff, last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   mht_pkg::entry_type wr_data;
   logic [AW-1:0]      rd_addr;
   mht_pkg::entry_type rd_data;

   // the one comparator, shared by the tick check, up compare, child select and down compare
   logic [31:0] cmp_a, cmp_b;
   logic        cmp_lt;

   logic [AW-1:0] parent;
   logic [AW+1:0] lc, rc, count_x;
   logic [31:0]   new_exp;
   logic          full;

   assign cmp_lt  = cmp_a < cmp_b;
   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign lc      = {1'b0, pos_ff, 1'b1};
   assign rc      = {1'b0, pos_ff, 1'b0} + (AW+2)'(2);
   assign count_x = (AW+2)'(count_ff);
   assign new_exp = mht_pkg::sat_add(item_ff.now_time, item_ff.timeout_value);
   assign full    = count_ff >= CW'(HEAP_DEPTH);

   mht_ram #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (state_ff)
         mht_pkg::ST_UP_CMP:     begin cmp_a = cand_ff.expiry;    cmp_b = rd_data.expiry; end
         mht_pkg::ST_DN_SEL:     begin cmp_a = rd_data.expiry;    cmp_b = left_ff.expiry; end
         mht_pkg::ST_DN_CMP:     begin cmp_a = best_ff.expiry;    cmp_b = cand_ff.expiry; end
         default:                begin cmp_a = item_ff.now_time;  cmp_b = root_ff.expiry; end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mht_pkg::ST_IDLE: begin
            if (req_valid) state_in = mht_pkg::ST_DISPATCH;
         end
         mht_pkg::ST_DISPATCH: begin
            if (item_ff.kind == mht_pkg::KIND_TICK) begin
               state_in = mht_pkg::ST_TICK_CHECK;
            end else if (item_ff.timeout_value == 32'd0 || full || count_ff == CW'(0)) begin
               state_in = mht_pkg::ST_EMIT;
            end else begin
               state_in = mht_pkg::ST_UP_READ;
            end
         end
         mht_pkg::ST_UP_READ: state_in = mht_pkg::ST_UP_CMP;
         mht_pkg::ST_UP_CMP: begin
            if (!cmp_lt) begin
               state_in = mht_pkg::ST_EMIT;
            end else if (parent == AW'(0)) begin
               state_in = mht_pkg::ST_UP_PLACE;
            end else begin
               state_in = mht_pkg::ST_UP_READ;
            end
         end
         mht_pkg::ST_UP_PLACE: state_in = mht_pkg::ST_EMIT;
         mht_pkg::ST_TICK_CHECK: begin
            if (count_ff != CW'(0) && !cmp_lt) begin
               state_in = mht_pkg::ST_POP_LAST;
            end else begin
               state_in = mht_pkg::ST_EMIT;
            end
         end
         mht_pkg::ST_POP_LAST: state_in = mht_pkg::ST_DN_READ_L;
         mht_pkg::ST_DN_READ_L: begin
            state_in = (lc >= count_x) ? mht_pkg::ST_EMIT : mht_pkg::ST_DN_READ_R;
         end
         mht_pkg::ST_DN_READ_R: begin
            state_in = (rc < count_x) ? mht_pkg::ST_DN_SEL : mht_pkg::ST_DN_CMP;
         end
         mht_pkg::ST_DN_SEL: state_in = mht_pkg::ST_DN_CMP;
         mht_pkg::ST_DN_CMP: begin
            state_in = cmp_lt ? mht_pkg::ST_DN_READ_L : mht_pkg::ST_EMIT;
         end
         mht_pkg::ST_EMIT: begin
            if (res_ready) begin
               state_in = last_ff ? mht_pkg::ST_IDLE : mht_pkg::ST_TICK_CHECK;
            end
         end
         default: state_in = mht_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      item_in      = item_ff;
      cand_in      = cand_ff;
      left_in      = left_ff;
      best_in      = best_ff;
      pos_in       = pos_ff;
      best_idx_in  = best_idx_ff;
      has_right_in = has_right_ff;
      status_in    = status_ff;
      res_exp_in   = res_exp_ff;
      res_tmo_in   = res_tmo_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cand_ff;
      rd_addr      = parent;
      req_ready    = 1'b0;
      res_valid    = 1'b0;

      case (state_ff)
         mht_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) item_in = req_data;
         end
         mht_pkg::ST_DISPATCH: begin
            res_exp_in = 32'd0;
            res_tmo_in = 32'd0;
            last_in    = 1'b1;
            if (item_ff.kind == mht_pkg::KIND_ADD) begin
               if (item_ff.timeout_value == 32'd0) begin
                  status_in = mht_pkg::STATUS_REJECTED;
               end else if (full) begin
                  status_in = mht_pkg::STATUS_FULL;
               end else begin
                  status_in  = mht_pkg::STATUS_ADDED;
                  res_exp_in = new_exp;
                  res_tmo_in = item_ff.timeout_value;
                  cand_in    = '{expiry: new_exp, timeout: item_ff.timeout_value};
                  pos_in     = AW'(count_ff);
                  count_in   = count_ff + CW'(1);
                  // empty heap: new entry lands at the root directly
                  if (count_ff == CW'(0)) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(0);
                     wr_data = '{expiry: new_exp, timeout: item_ff.timeout_value};
                  end
               end
            end
         end
         mht_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               // parent is later: pull it down into the hole
               wr_data = rd_data;
               pos_in  = parent;
            end
         end
         mht_pkg::ST_UP_PLACE: begin
            wr_en = 1'b1;
         end
         mht_pkg::ST_TICK_CHECK: begin
            rd_addr = AW'(count_ff - CW'(1));
            if (count_ff != CW'(0) && !cmp_lt) begin
               status_in  = mht_pkg::STATUS_EXPIRED;
               res_exp_in = root_ff.expiry;
               res_tmo_in = root_ff.timeout;
               last_in    = 1'b0;
               count_in   = count_ff - CW'(1);
            end else begin
               status_in  = mht_pkg::STATUS_DONE;
               res_exp_in = 32'd0;
               res_tmo_in = 32'd0;
               last_in    = 1'b1;
            end
         end
         mht_pkg::ST_POP_LAST: begin
            cand_in = rd_data;
            pos_in  = AW'(0);
         end
         mht_pkg::ST_DN_READ_L: begin
            rd_addr = lc[AW-1:0];
            if (lc >= count_x) wr_en = 1'b1;
         end
         mht_pkg::ST_DN_READ_R: begin
            rd_addr      = rc[AW-1:0];
            left_in      = rd_data;
            best_in      = rd_data;
            best_idx_in  = lc[AW-1:0];
            has_right_in = rc < count_x;
         end
         mht_pkg::ST_DN_SEL: begin
            // right child wins only when strictly earlier
            if (cmp_lt) begin
               best_in     = rd_data;
               best_idx_in = rc[AW-1:0];
            end
         end
         mht_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data = best_ff;
               pos_in  = best_idx_ff;
            end
         end
         mht_pkg::ST_EMIT: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // root mirror tracks every write to slot zero
   always_comb begin
      root_in = root_ff;
      if (wr_en && wr_addr == AW'(0)) root_in = wr_data;
   end

   always_comb begin
      res_data.status          = status_ff;
      res_data.expire_time     = res_exp_ff;
      res_data.expired_timeout = res_tmo_ff;
      res_data.entries_left    = 5'(count_ff);
      res_data.next_expire     = (count_ff != CW'(0)) ? root_ff.expiry : 32'd0;
      res_data.last            = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mht_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      item_ff      <= item_in;
      cand_ff      <= cand_in;
      left_ff      <= left_in;
      best_ff      <= best_in;
      pos_ff       <= pos_in;
      best_idx_ff  <= best_idx_in;
      has_right_ff <= has_right_in;
      status_ff    <= status_in;
      res_exp_ff   <= res_exp_in;
      res_tmo_ff   <= res_tmo_in;
      last_ff      <= last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("heap count above depth");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (AW+1)'(wr_addr) < (AW+1)'(HEAP_DEPTH))
      else $error("heap write outside storage");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready && res_data.last |=> req_ready)
      else $error("not ready after final result");

   a_added_nonempty: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.status == mht_pkg::STATUS_ADDED |-> count_ff != CW'(0))
      else $error("added result with empty heap");

   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.status == mht_pkg::STATUS_EXPIRED |-> !res_data.last)
      else $error("expired result flagged last");

   a_right_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff == mht_pkg::ST_DN_SEL |-> has_right_ff)
      else $error("right child compare without right child");

endmodule

### rtl/min_heap_timer_queue.sv
// Channel   Direction  Payload            Transaction when
// req_*     in         mht_pkg::req_type  req_valid && req_ready
// rsp_*     out        mht_pkg::rsp_type  rsp_valid && rsp_ready
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Add: rejected, full or into an empty heap goes straight to the result; otherwise
// one RAM read and one compare per parent compared, plus a place step at the root.
// Tick: a root check, plus per expired timer a pop of the last entry and per level of
// sift-down up to two child reads and two passes through the shared comparator.
// Results sit in an output register; a stalled rsp_ready holds the sequencer.
// Reset is synchronous and empties the heap; no clearing pass is needed.
module min_heap_timer_queue #(
   parameter int HEAP_DEPTH = mht_pkg::DEFAULT_HEAP_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mht_pkg::rsp_type rsp_data
);

   logic             res_valid;
   logic             res_ready;
   mht_pkg::rsp_type res_data;

   logic             rsp_valid_ff, rsp_valid_in;
   mht_pkg::rsp_type rsp_data_ff, rsp_data_in;

   mht_core #(.HEAP_DEPTH(HEAP_DEPTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_DEPTH = mht_pkg::DEFAULT_HEAP_DEPTH;
   localparam int PER_PHASE  = 31;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mht_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mht_pkg::rsp_type rsp_data;

   min_heap_timer_queue #(.HEAP_DEPTH(HEAP_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted timer heap
   logic [31:0] tq_expiry [HEAP_DEPTH];
   logic [31:0] tq_timeout[HEAP_DEPTH];
   int          tq_count = 0;

   mht_pkg::req_type timer_reqs[$];
   mht_pkg::rsp_type pending_results[$];
   mht_pkg::rsp_type oldest_result;
   int      req_idle_pct  = 0;
   int      rsp_stall_pct = 0;
   int      mismatch_count = 0;

   function automatic void push_result(logic [2:0] st, logic [31:0] exp_t,
                                       logic [31:0] tmo, logic lst);
      mht_pkg::rsp_type r;
      r.status          = st;
      r.expire_time     = exp_t;
      r.expired_timeout = tmo;
      r.entries_left    = tq_count[4:0];
      r.next_expire     = (tq_count != 0) ? tq_expiry[0] : 32'd0;
      r.last            = lst;
      pending_results.push_back(r);
   endfunction

   function automatic void advance_timer_heap(mht_pkg::req_type item);
      logic [32:0] sum;
      logic [31:0] exp_t;
      logic [31:0] e;
      logic [31:0] t;
      int          hole;
      int          parent;
      int          pos;
      int          c;
      bit          moving;
      if (item.kind == mht_pkg::KIND_ADD) begin
         if (item.timeout_value == 32'd0) begin
            push_result(mht_pkg::STATUS_REJECTED, 32'd0, 32'd0, 1'b1);
         end else if (tq_count >= HEAP_DEPTH) begin
            push_result(mht_pkg::STATUS_FULL, 32'd0, 32'd0, 1'b1);
         end else begin
            sum   = {1'b0, item.now_time} + {1'b0, item.timeout_value};
            exp_t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            hole  = tq_count;
            tq_count++;
            moving = 1'b1;
            while (moving && hole > 0) begin
               parent = (hole - 1) / 2;
               if (tq_expiry[parent] <= exp_t) begin
                  moving = 1'b0;
               end else begin
                  tq_expiry[hole]  = tq_expiry[parent];
                  tq_timeout[hole] = tq_timeout[parent];
                  hole = parent;
               end
            end
            tq_expiry[hole]  = exp_t;
            tq_timeout[hole] = item.timeout_value;
            push_result(mht_pkg::STATUS_ADDED, exp_t, item.timeout_value, 1'b1);
         end
      end else begin
         while (tq_count > 0 && tq_expiry[0] <= item.now_time) begin
            e = tq_expiry[0];
            t = tq_timeout[0];
            tq_count--;
            tq_expiry[0]  = tq_expiry[tq_count];
            tq_timeout[0] = tq_timeout[tq_count];
            // sift down: only to a strictly smaller child, right only if strictly smaller
            pos = 0;
            moving = 1'b1;
            while (moving) begin
               c = 2 * pos + 1;
               if (c >= tq_count) begin
                  moving = 1'b0;
               end else begin
                  if (c + 1 < tq_count && tq_expiry[c + 1] < tq_expiry[c]) c++;
                  if (tq_expiry[c] < tq_expiry[pos]) begin
                     exp_t = tq_expiry[pos];
                     tq_expiry[pos] = tq_expiry[c];
                     tq_expiry[c] = exp_t;
                     exp_t = tq_timeout[pos];
                     tq_timeout[pos] = tq_timeout[c];
                     tq_timeout[c] = exp_t;
                     pos = c;
                  end else begin
                     moving = 1'b0;
                  end
               end
            end
            push_result(mht_pkg::STATUS_EXPIRED, e, t, 1'b0);
         end
         push_result(mht_pkg::STATUS_DONE, 32'd0, 32'd0, 1'b1);
      end
   endfunction

   task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) advance_timer_heap(req_data);
         if (!req_valid || req_ready) begin
            if (timer_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_data  <= timer_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %p",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_result = pending_results.pop_front();
               check_field("status", 32'(oldest_result.status), 32'(rsp_data.status));
               check_field("expire_time", oldest_result.expire_time,
                           rsp_data.expire_time);
               check_field("expired_timeout", oldest_result.expired_timeout,
                           rsp_data.expired_timeout);
               check_field("entries_left", 32'(oldest_result.entries_left),
                           32'(rsp_data.entries_left));
               check_field("next_expire", oldest_result.next_expire,
                           rsp_data.next_expire);
               check_field("last", 32'(oldest_result.last), 32'(rsp_data.last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic queue_item(logic kind, logic [31:0] now_t, logic [31:0] tmo);
      mht_pkg::req_type it;
      it.kind          = kind;
      it.now_time      = now_t;
      it.timeout_value = tmo;
      timer_reqs.push_back(it);
   endtask

   initial begin
      int          phase;
      int          i;
      int          sel;
      logic [31:0] clk_now;
      logic [31:0] fill_tmo[13];
      fill_tmo = '{10, 5, 5, 20, 1, 5, 10, 10, 3, 3, 7, 5, 1};
      clk_now  = $urandom_range(1000);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin req_idle_pct = 23; rsp_stall_pct = 23; end
         endcase

         if (phase == 0) begin
            queue_item(mht_pkg::KIND_TICK, 32'd0, 32'hFFFF_FFFF);        // empty heap
            queue_item(mht_pkg::KIND_ADD, 32'd0, 32'd0);                 // zero timeout
            queue_item(mht_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // saturates
            queue_item(mht_pkg::KIND_ADD, 32'd0, 32'hFFFF_FFFF);
            queue_item(mht_pkg::KIND_ADD, 32'd0, 32'd1);
            queue_item(mht_pkg::KIND_TICK, 32'd0, 32'd0);                // nothing due
            // fill with many equal expiries
            for (i = 0; i < 13; i++) queue_item(mht_pkg::KIND_ADD, 32'd100, fill_tmo[i]);
            queue_item(mht_pkg::KIND_ADD, 32'd100, 32'd2);               // heap full
            queue_item(mht_pkg::KIND_TICK, 32'hFFFF_FFFF, 32'd0);        // drains all 16
            queue_item(mht_pkg::KIND_TICK, 32'hFFFF_FFFF, 32'd7);
            queue_item(mht_pkg::KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF); // exact max
            queue_item(mht_pkg::KIND_ADD, 32'h8000_0000, 32'h8000_0000); // off by one
            queue_item(mht_pkg::KIND_TICK, 32'h7FFF_FFFF, 32'd0);
         end

         for (i = 0; i < PER_PHASE; i++) begin
            sel = $urandom_range(99);
            if ($urandom_range(19) == 0) clk_now = $urandom;
            if (sel < 55) begin
               queue_item(mht_pkg::KIND_ADD, clk_now, $urandom_range(60, 1));
            end else if (sel < 65) begin
               queue_item(mht_pkg::KIND_ADD, $urandom, $urandom);
            end else if (sel < 69) begin
               queue_item(mht_pkg::KIND_ADD, clk_now, 32'd0);
            end else if (sel < 94) begin
               clk_now = clk_now + $urandom_range(40);
               queue_item(mht_pkg::KIND_TICK, clk_now, $urandom);
            end else begin
               queue_item(mht_pkg::KIND_TICK, $urandom, $urandom);
            end
         end

         while (timer_reqs.size() != 0 || req_valid || pending_results.size() != 0)
            @(negedge clock);
      end

      repeat (60) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
